>>> rtl/bsd_pkg.sv
package bsd_pkg;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_INSERT     = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_SWAP       = 3'd6,
    OP_DUMP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_DUMP_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [4:0]         element_index;
    logic [5:0]         count;
    status_t            status;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    logic exec;
    logic dump_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic dump_last;
  } dp_stat_t;

endpackage

>>> rtl/bsd_ctrl.sv
module bsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bsd_pkg::op_t       operation,
  input  bsd_pkg::dp_stat_t  stat,
  output bsd_pkg::ctrl_cmd_t cmd,
  output logic               busy
);

  bsd_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsd_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsd_pkg::FSM_IDLE: begin
        if (start && operation == bsd_pkg::OP_DUMP && !stat.empty) begin
          state_nxt = bsd_pkg::FSM_DUMP;
        end
      end
      bsd_pkg::FSM_DUMP: begin
        if (stat.dump_last) begin
          state_nxt = bsd_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = bsd_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    busy          = 1'b0;
    case (state_r)
      bsd_pkg::FSM_IDLE: begin
        cmd.exec = start;
      end
      bsd_pkg::FSM_DUMP: begin
        cmd.dump_step = 1'b1;
        busy          = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

>>> rtl/bsd_dp.sv
module bsd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  bsd_pkg::in_req_t   req,
  input  bsd_pkg::ctrl_cmd_t cmd,
  output bsd_pkg::dp_stat_t  stat,
  output bsd_pkg::out_rsp_t  rsp,
  output logic               strobe
);

  logic signed [31:0] store_r   [bsd_pkg::DEPTH];
  logic signed [31:0] store_nxt [bsd_pkg::DEPTH];

  logic [bsd_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [bsd_pkg::IDX_W-1:0] dump_idx_r, dump_idx_nxt;
  logic                      strobe_r, strobe_nxt;
  bsd_pkg::out_rsp_t         rsp_r, rsp_nxt;

  logic                      full, empty, pos_ge;
  logic [bsd_pkg::CNT_W-1:0] tail_w;
  logic [bsd_pkg::IDX_W-1:0] tail, ins_t, rd_addr;
  logic signed [31:0]        rd_data;
  bsd_pkg::status_t          status;

  assign full    = count_r == bsd_pkg::CNT_W'(bsd_pkg::DEPTH);
  assign empty   = count_r == '0;
  assign tail_w  = count_r - bsd_pkg::CNT_W'(1);
  assign tail    = tail_w[bsd_pkg::IDX_W-1:0];
  assign pos_ge  = bsd_pkg::CMP_W'(req.position) >= bsd_pkg::CMP_W'(count_r);
  assign rd_addr = cmd.dump_step ? dump_idx_r : tail;
  assign rd_data = store_r[rd_addr];

  always_comb begin
    if (req.operation == bsd_pkg::OP_PUSH_FRONT) begin
      ins_t = '0;
    end else if (req.operation == bsd_pkg::OP_PUSH_BACK || pos_ge) begin
      ins_t = bsd_pkg::IDX_W'(count_r);
    end else begin
      ins_t = bsd_pkg::IDX_W'(req.position);
    end
  end

  always_comb begin
    for (int i = 0; i < bsd_pkg::DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    count_nxt = count_r;
    status    = bsd_pkg::ST_OK;
    if (cmd.exec) begin
      case (req.operation)
        bsd_pkg::OP_CLEAR: count_nxt = '0;
        bsd_pkg::OP_PUSH_FRONT, bsd_pkg::OP_PUSH_BACK, bsd_pkg::OP_INSERT: begin
          if (full) begin
            status = bsd_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < bsd_pkg::DEPTH; i++) begin
              if (bsd_pkg::IDX_W'(i) == ins_t) begin
                store_nxt[i] = req.value;
              end else if (i > 0 && bsd_pkg::IDX_W'(i) > ins_t) begin
                store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
              end
            end
            count_nxt = count_r + bsd_pkg::CNT_W'(1);
          end
        end
        bsd_pkg::OP_POP_FRONT, bsd_pkg::OP_POP_BACK: begin
          if (empty) begin
            status = bsd_pkg::ST_EMPTY;
          end else begin
            if (req.operation == bsd_pkg::OP_POP_FRONT) begin
              for (int i = 0; i < bsd_pkg::DEPTH - 1; i++) begin
                store_nxt[i] = store_r[i + 1];
              end
            end
            count_nxt = tail_w;
          end
        end
        bsd_pkg::OP_SWAP: begin
          if (!empty && count_r != bsd_pkg::CNT_W'(1)) begin
            store_nxt[0] = rd_data;
            for (int i = 1; i < bsd_pkg::DEPTH; i++) begin
              if (bsd_pkg::IDX_W'(i) == tail) begin
                store_nxt[i] = store_r[0];
              end
            end
          end
        end
        bsd_pkg::OP_DUMP: begin
          if (empty) begin
            status = bsd_pkg::ST_DUMP_EMPTY;
          end
        end
        default: status = bsd_pkg::ST_OK;
      endcase
    end
  end

  always_comb begin
    dump_idx_nxt = dump_idx_r;
    strobe_nxt   = 1'b0;
    rsp_nxt      = rsp_r;
    if (cmd.exec) begin
      dump_idx_nxt          = '0;
      strobe_nxt            = !(req.operation == bsd_pkg::OP_DUMP && !empty);
      rsp_nxt.element       = '0;
      rsp_nxt.element_index = '0;
      rsp_nxt.count         = 6'(count_nxt);
      rsp_nxt.status        = status;
      rsp_nxt.last          = 1'b1;
    end else if (cmd.dump_step) begin
      dump_idx_nxt          = dump_idx_r + bsd_pkg::IDX_W'(1);
      strobe_nxt            = 1'b1;
      rsp_nxt.element       = rd_data;
      rsp_nxt.element_index = 5'(dump_idx_r);
      rsp_nxt.count         = 6'(count_r);
      rsp_nxt.status        = bsd_pkg::ST_OK;
      rsp_nxt.last          = stat.dump_last;
    end
  end

  assign stat.empty     = empty;
  assign stat.dump_last = dump_idx_r == tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r    <= store_nxt;
    dump_idx_r <= dump_idx_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign rsp    = rsp_r;
  assign strobe = strobe_r;

endmodule

>>> rtl/bounded_sequence_deque_top.sv
// Channel   Handshake            Payload
// request   start / busy         in_req  (operation, value, position)
// result    out_strobe, 1 cycle  out_rsp (element, element_index, count, status, last)
//
// Every operation but a dump of a nonempty store answers in the cycle after it is
// taken, and a new request can be taken in each cycle while busy is low.
// A dump holds busy while it emits the stored elements, one element a cycle
// through the single store read port; the next request is taken after that.
// Synchronous active-low reset empties the store; stored words are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module bounded_sequence_deque_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bsd_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output bsd_pkg::out_rsp_t out_rsp
);

  bsd_pkg::ctrl_cmd_t cmd;
  bsd_pkg::dp_stat_t  stat;

  bsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_req.operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bsd_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (in_req),
    .cmd    (cmd),
    .stat   (stat),
    .rsp    (out_rsp),
    .strobe (out_strobe)
  );

endmodule
